/* sv/float_to_decimal_text_assert.svh */
// Assertion macros shared by the float_to_decimal_text RTL.
`ifndef FLOAT_TO_DECIMAL_TEXT_ASSERT_SVH
`define FLOAT_TO_DECIMAL_TEXT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FTDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ftdt_pkg.sv */
// Shared types and constants for the double-to-decimal-text block.
`default_nettype none

package ftdt_pkg;

  localparam int unsigned MaxFracDigitsDef = 18;
  localparam int unsigned FracBitsDef      = 64;

  localparam int unsigned BcdDigits = 10;
  localparam int unsigned IntBits   = 31;

  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_NINE  = 8'h39;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [7:0]  CH_DOT   = 8'h2E;

  localparam logic [30:0] INT_SAT  = 31'h7FFF_FFFF;
  localparam logic [4:0]  FRAC_DIGITS_RST = 5'd6;
  localparam logic [2:0]  ADDR_FRAC_DIGITS = 3'd0;

  // Alignment request: shift direction and distance in bits.
  typedef struct packed {
    logic       left;
    logic [6:0] amount;
  } align_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_CONV,
    ST_SIGN,
    ST_INT,
    ST_DOT,
    ST_FRAC
  } ftdt_state_e;

endpackage

`default_nettype wire

/* sv/ftdt_align.sv */
// Iterative shifter: places the mantissa on a 32.64 fixed-point grid, up to 8 bits a cycle.
`default_nettype none

module ftdt_align
  import ftdt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire align_cmd_t  cmd_i,
  input  wire logic [52:0] mant_i,
  output logic             done_o,
  output logic [95:0]      fixed_o
);

  logic [95:0] x_q, x_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        left_q, left_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [3:0]  step;

  assign step = (cnt_q > 7'd8) ? 4'd8 : cnt_q[3:0];

  always_comb begin
    x_d    = x_q;
    cnt_d  = cnt_q;
    left_d = left_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (load_i) begin
      x_d    = {43'd0, mant_i};
      cnt_d  = cmd_i.amount;
      left_d = cmd_i.left;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (cnt_q == 7'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        x_d   = left_q ? (x_q << step) : (x_q >> step);
        cnt_d = cnt_q - {3'd0, step};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    cnt_q  <= cnt_d;
    left_q <= left_d;
  end

  assign done_o  = done_q;
  assign fixed_o = x_q;

endmodule

`default_nettype wire

/* sv/ftdt_bcd.sv */
// Serial binary-to-BCD converter (shift and add-3), one bit per cycle.
`default_nettype none

module ftdt_bcd
  import ftdt_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire logic [IntBits-1:0]       bin_i,
  output logic                          done_o,
  output logic [4*BcdDigits-1:0]        bcd_o
);

  localparam int unsigned CntW = $clog2(IntBits + 1);

  logic [IntBits-1:0]     bin_q, bin_d;
  logic [4*BcdDigits-1:0] bcd_q, bcd_d, adj;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   run_q, run_d;
  logic                   done_q, done_d;

  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (load_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = CntW'(IntBits);
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[4*BcdDigits-2:0], bin_q[IntBits-1]};
      bin_d = bin_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

/* sv/float_to_decimal_text.sv */
// Top level: double bit pattern in, fixed-point decimal text out one character per cycle.
`default_nettype none

// Converts one IEEE double to text: optional '-', integer digits, then, if the
// digit count (frac_digits capped at MAX_FRAC_DIGITS) is nonzero, '.' and that many
// truncated fraction digits. An item is taken on start while busy is low; busy
// drops in the cycle that shows the last character on the outputs. Each character
// shows on char_code_o for one cycle with valid_o high and cannot be held off.
// Steps per item: the fields are unpacked at the accepting edge, then (values
// below 2^31 only) the mantissa is aligned by a shift of A <= 64 bits, then the
// integer part goes through serial binary-to-BCD conversion, then the text leaves
// one character per cycle (up to 30) through an output register. Magnitudes of 2^31
// and above, infinity and NaN print 2147483647 with overflow_o high on every character.
module float_to_decimal_text
  import ftdt_pkg::*;
#(
  parameter int unsigned MAX_FRAC_DIGITS = MaxFracDigitsDef,
  parameter int unsigned FRAC_BITS       = FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] value_bits_i,
  output logic             valid_o,
  output logic [7:0]       char_code_o,
  output logic             last_o,
  output logic             overflow_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned FcW = $clog2(MAX_FRAC_DIGITS + 1);
  localparam logic [63:0] FracMask = ~((64'd1 << (64 - FRAC_BITS)) - 64'd1);

  ftdt_state_e state_q, state_d;

  logic [4:0]     frac_digits_q;
  logic [4:0]     nf_q;
  logic           minus_q, ovf_q;
  logic [63:0]    frac_q;
  logic [3:0]     di_q;
  logic [FcW-1:0] fcnt_q;

  logic           accept;
  logic           sign_bit;
  logic [10:0]    expo;
  logic [51:0]    mant;
  logic           in_ovf, in_minus;
  logic [10:0]    sh;
  logic [10:0]    sh_right;
  align_cmd_t     acmd;
  logic           align_done;
  logic [95:0]    fixed;
  logic           conv_load;
  logic [30:0]    conv_val;
  logic           conv_done;
  logic [39:0]    bcd;
  logic [3:0]     lead;
  logic [67:0]    prod;
  logic [3:0]     cur_digit;

  logic           emit;
  logic [7:0]     ch;
  logic           ch_last;
  logic           valid_q;
  logic [7:0]     char_q;
  logic           last_q;
  logic           ovf_out_q;
  logic           char_ok;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FRAC_DIGITS) ? {27'd0, frac_digits_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_digits_q <= FRAC_DIGITS_RST;
    end else if (psel && penable && pwrite && paddr == ADDR_FRAC_DIGITS) begin
      frac_digits_q <= pwdata[4:0];
    end
  end

  // Unpack
  assign accept   = start && !busy;
  assign sign_bit = value_bits_i[63];
  assign expo     = value_bits_i[62:52];
  assign mant     = value_bits_i[51:0];
  assign in_ovf   = (expo == 11'h7FF) || (expo >= 11'd1054);
  assign in_minus = sign_bit && !(expo == 11'h7FF && mant != 52'd0)
                    && (value_bits_i[62:0] != 63'd0);
  assign sh       = (expo == 11'd0) ? 11'd1074 : 11'd1075 - expo;
  assign sh_right = sh - 11'd64;

  always_comb begin
    acmd.left = (sh <= 11'd64);
    if (sh <= 11'd64) begin
      acmd.amount = 7'(11'd64 - sh);
    end else if (sh_right > 11'd64) begin
      acmd.amount = 7'd64;
    end else begin
      acmd.amount = sh_right[6:0];
    end
  end

  ftdt_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept && !in_ovf),
    .cmd_i   (acmd),
    .mant_i  ({expo != 11'd0, mant}),
    .done_o  (align_done),
    .fixed_o (fixed)
  );

  assign conv_load = (accept && in_ovf) || (state_q == ST_ALIGN && align_done);
  assign conv_val  = accept ? INT_SAT : fixed[94:64];

  ftdt_bcd u_bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (conv_load),
    .bin_i  (conv_val),
    .done_o (conv_done),
    .bcd_o  (bcd)
  );

  // Most significant nonzero BCD digit; a zero integer part prints one '0'.
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) lead = 4'(i);
    end
  end

  assign prod      = {1'b0, frac_q, 3'd0} + {3'd0, frac_q, 1'b0};
  assign cur_digit = bcd[di_q*4 +: 4];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = in_ovf ? ST_CONV : ST_ALIGN;
      end
      ST_ALIGN: begin
        if (align_done) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_d = minus_q ? ST_SIGN : ST_INT;
      end
      ST_SIGN: state_d = ST_INT;
      ST_INT: begin
        if (di_q == 4'd0) state_d = (nf_q != 5'd0) ? ST_DOT : ST_IDLE;
      end
      ST_DOT: state_d = ST_FRAC;
      ST_FRAC: begin
        if (5'(fcnt_q) + 5'd1 == nf_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Character output
  always_comb begin
    emit    = 1'b0;
    ch      = CH_ZERO;
    ch_last = 1'b0;
    case (state_q)
      ST_SIGN: begin
        emit = 1'b1;
        ch   = CH_MINUS;
      end
      ST_INT: begin
        emit    = 1'b1;
        ch      = CH_ZERO + {4'd0, cur_digit};
        ch_last = (di_q == 4'd0) && (nf_q == 5'd0);
      end
      ST_DOT: begin
        emit = 1'b1;
        ch   = CH_DOT;
      end
      ST_FRAC: begin
        emit    = 1'b1;
        ch      = CH_ZERO + {4'd0, prod[67:64]};
        ch_last = (5'(fcnt_q) + 5'd1 == nf_q);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q    <= ch;
    last_q    <= ch_last;
    ovf_out_q <= ovf_q;
    if (accept) begin
      minus_q <= in_minus;
      ovf_q   <= in_ovf;
      nf_q    <= (frac_digits_q > 5'(MAX_FRAC_DIGITS)) ? 5'(MAX_FRAC_DIGITS) : frac_digits_q;
      frac_q  <= 64'd0;
    end
    if (state_q == ST_ALIGN && align_done) begin
      frac_q <= fixed[63:0] & FracMask;
    end
    if (state_q == ST_CONV && conv_done) begin
      di_q <= lead;
    end
    if (state_q == ST_INT) begin
      di_q <= di_q - 4'd1;
    end
    if (state_q == ST_DOT) begin
      fcnt_q <= '0;
    end
    if (state_q == ST_FRAC) begin
      frac_q <= prod[63:0];
      fcnt_q <= fcnt_q + 1'b1;
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign valid_o     = valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;
  assign overflow_o  = ovf_out_q;

  assign char_ok = (char_code_o >= CH_ZERO && char_code_o <= CH_NINE)
                   || char_code_o == CH_MINUS || char_code_o == CH_DOT;

`include "float_to_decimal_text_assert.svh"

  `FTDT_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transfer did not raise busy")
  `FTDT_ASSERT_NOW(a_char_legal, valid_o, char_ok, "illegal character code")
  `FTDT_ASSERT_NOW(a_midtext_busy, valid_o && !last_o, busy, "text ended without last")
  `FTDT_ASSERT_NEXT(a_last_idle, valid_o && last_o, !valid_o, "character after last")

endmodule

`default_nettype wire

/* tb/ftdt_text_checker.sv */
// Checker for float_to_decimal_text: predicts the character stream and compares it.
`timescale 1ns / 100ps

module ftdt_text_checker
  import ftdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [63:0] value_bits_i,
  input  logic        valid_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_i,
  input  logic        overflow_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          error_count_o,
  output int          pending_count_o
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       ovf;
  } text_char_t;

  localparam logic [63:0] FracMask = ~((64'd1 << (64 - FracBitsDef)) - 64'd1);

  text_char_t expected_chars[$];
  logic [4:0] digits_cfg;
  int         errors;

  // Builds the text of one double and queues its characters.
  function automatic void predict_text(input logic [63:0] bits, input logic [4:0] ndigits);
    logic        sign;
    logic [10:0] expo;
    logic [51:0] mant;
    logic [52:0] m;
    int unsigned s;
    logic [31:0] ipart;
    logic [63:0] frac;
    logic        ovf;
    logic        minus;
    logic [3:0]  dec [10];
    int          nd;
    int          nf;
    logic [67:0] prod;
    text_char_t  ch;
    sign  = bits[63];
    expo  = bits[62:52];
    mant  = bits[51:0];
    ipart = '0;
    frac  = '0;
    ovf   = 1'b0;
    if (expo == 11'd0) begin
      m = {1'b0, mant};
      s = 1074;
    end else begin
      m = {1'b1, mant};
      s = (expo >= 11'd1075) ? 0 : 1075 - int'(expo);
    end
    if (expo == 11'h7FF || expo >= 11'd1054) begin
      ipart = {1'b0, INT_SAT};
      ovf   = 1'b1;
    end else if (s == 0) begin
      ipart = m[31:0];
    end else begin
      ipart = (s >= 64) ? 32'd0 : 32'(m >> s);
      if (s <= 64) frac = (s == 64) ? 64'(m) : (64'(m) << (64 - s));
      else if (s - 64 < 64) frac = 64'(m) >> (s - 64);
      else frac = '0;
      frac &= FracMask;
    end
    // NaN never gets a sign, and neither does negative zero
    minus = sign && !(expo == 11'h7FF && mant != '0) && (expo != '0 || mant != '0);
    nf = (ndigits > MaxFracDigitsDef) ? MaxFracDigitsDef : int'(ndigits);
    nd = 0;
    do begin
      dec[nd] = 4'(ipart % 10);
      ipart   = ipart / 10;
      nd++;
    end while (ipart != 0 && nd < 10);
    if (minus) begin
      ch = '{code: CH_MINUS, last: 1'b0, ovf: ovf};
      expected_chars.push_back(ch);
    end
    while (nd > 0) begin
      nd--;
      ch = '{code: CH_ZERO + 8'(dec[nd]), last: (nd == 0 && nf == 0), ovf: ovf};
      expected_chars.push_back(ch);
    end
    if (nf != 0) begin
      ch = '{code: CH_DOT, last: 1'b0, ovf: ovf};
      expected_chars.push_back(ch);
      for (int i = 0; i < nf; i++) begin
        prod = 68'(frac) * 68'd10;
        ch   = '{code: CH_ZERO + 8'(prod[67:64]), last: (i + 1 == nf), ovf: ovf};
        expected_chars.push_back(ch);
        frac = prod[63:0];
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      digits_cfg      = FRAC_DIGITS_RST;
      errors          = 0;
      error_count_o   <= 0;
      pending_count_o <= 0;
    end else begin
      if (valid_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char %h last %b ovf %b, nothing pending",
                   $time, char_code_i, last_i, overflow_i);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (want.code !== char_code_i || want.last !== last_i || want.ovf !== overflow_i) begin
            $display("%0t: char mismatch, expected %h last %b ovf %b, got %h last %b ovf %b",
                     $time, want.code, want.last, want.ovf, char_code_i, last_i, overflow_i);
            errors++;
          end
        end
      end
      if (start_i && !busy_i) predict_text(value_bits_i, digits_cfg);
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_FRAC_DIGITS)
        digits_cfg = pwdata_i[4:0];
      error_count_o   <= errors;
      pending_count_o <= expected_chars.size();
    end
  end

endmodule

/* tb/tb_float_to_decimal_text.sv */
// Testbench top for float_to_decimal_text: stimulus, register setup and verdict.
`timescale 1ns / 100ps

module tb_float_to_decimal_text;
  import ftdt_pkg::*;

  localparam int          IdleLimit     = 4000;
  localparam int          DrainCycles   = 8;
  localparam int          NumPhases     = 7;
  localparam int          ItemsPerPhase = 36;
  localparam logic [2:0]  AddrUnused    = ADDR_FRAC_DIGITS + 3'd4;
  localparam logic [63:0] DirectedValues [25] = '{
    64'h0000000000000000, 64'h8000000000000000, 64'h3FF0000000000000,
    64'hBFF0000000000000, 64'h3FE0000000000000, 64'hBFE0000000000000,
    64'h41DFFFFFFFC00000, 64'h41E0000000000000, 64'hC1E0000000000000,
    64'h7FF0000000000000, 64'hFFF0000000000000, 64'h7FF8000000000000,
    64'hFFFFFFFFFFFFFFFF, 64'h0000000000000001, 64'h800FFFFFFFFFFFFF,
    64'h0010000000000000, 64'h7FEFFFFFFFFFFFFF, 64'h3FB999999999999A,
    64'h400921FB54442D18, 64'hC05EDD2F1A9FBE77, 64'h41CDCD6500000000,
    64'h3BF0000000000000, 64'h3BE0000000000000, 64'h3FEFFFFFFFFFFFFF,
    64'hC1DFFFFFFFC00000
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [63:0] value_bits_i;
  logic        valid_o;
  logic [7:0]  char_code_o;
  logic        last_o;
  logic        overflow_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          error_count;
  int          pending_count;
  int          idle_cycles;

  float_to_decimal_text i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_bits_i(value_bits_i),
    .valid_o     (valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  ftdt_text_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .value_bits_i   (value_bits_i),
    .valid_i        (valid_o),
    .char_code_i    (char_code_o),
    .last_i         (last_o),
    .overflow_i     (overflow_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .error_count_o  (error_count),
    .pending_count_o(pending_count)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Watchdog: any transfer on either side or on the register port counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Integer-fitting normals (the largest share), fractions, specials and raw noise.
  function automatic logic [63:0] rand_double();
    logic [63:0] r;
    logic [10:0] e;
    int unsigned pick;
    r    = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick >= 8) return r;
    if (pick <= 3) e = 11'($urandom_range(1023, 1053));
    else if (pick <= 5) e = 11'($urandom_range(950, 1022));
    else if (pick == 6) begin
      case ($urandom_range(0, 2))
        0: e = 11'd0;
        1: e = 11'h7FF;
        default: e = 11'($urandom_range(1054, 1080));
      endcase
    end else e = 11'($urandom_range(0, 2047));
    if ($urandom_range(0, 7) == 0) r[51:0] = '0;
    r[62:52] = e;
    return r;
  endfunction

  task automatic send_value(input logic [63:0] bits);
    start        <= 1'b1;
    value_bits_i <= bits;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every expected character has arrived and the block has gone idle.
  task automatic wait_idle();
    do @(posedge clk_i); while (pending_count != 0 || busy);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [4:0]  cfg;
    int unsigned gap;
    bit          no_gaps;
    rst_ni       = 1'b0;
    start        = 1'b0;
    value_bits_i = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_cycles  = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed values at the reset digit count
    for (int n = 0; n < 25; n++) begin
      send_value(DirectedValues[n]);
      gap = pick_gap();
      if (gap != 0 || n == 24) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      case (p)
        0: cfg = 5'd0;
        1: cfg = 5'd18;
        2: cfg = 5'd31;
        3: cfg = 5'd1;
        default: cfg = 5'($urandom_range(0, 31));
      endcase
      write_reg(ADDR_FRAC_DIGITS, {27'($urandom), cfg});
      // writes to an unmapped register must leave the digit count alone
      if (p == 5) write_reg(AddrUnused, $urandom);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_value(rand_double());
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0 || n == ItemsPerPhase - 1) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/ftdt_pkg.sv
sv/ftdt_align.sv
sv/ftdt_bcd.sv
sv/float_to_decimal_text.sv
tb/ftdt_text_checker.sv
tb/tb_float_to_decimal_text.sv
